FILE: rtl/rpb_pkg.sv
package rpb_pkg;

	localparam logic [3:0] CMD_MULTIPLY   = 4'd0;
	localparam logic [3:0] CMD_SUBTRACT   = 4'd1;
	localparam logic [3:0] CMD_SCREEN     = 4'd2;
	localparam logic [3:0] CMD_OVERLAY    = 4'd3;
	localparam logic [3:0] CMD_ADD_GREEN  = 4'd4;
	localparam logic [3:0] CMD_SCALE_RED  = 4'd5;
	localparam logic [3:0] CMD_REP_BLUE   = 4'd6;
	localparam logic [3:0] CMD_REP_GREEN  = 4'd7;
	localparam logic [3:0] CMD_REP_RED    = 4'd8;

	localparam logic REG_GREEN_OFFSET = 1'b0;
	localparam logic REG_RED_GAIN     = 1'b1;

	localparam logic [7:0] GREEN_OFFSET_RESET = 8'd200;
	localparam logic [7:0] RED_GAIN_RESET     = 8'd4;

	localparam logic [7:0] CH_MAX      = 8'd255;
	localparam logic [7:0] OVERLAY_MID = 8'd127;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_DIV,
		MODE_DIV_INV,
		MODE_SAT
	} chan_mode_t;

	typedef struct packed {
		chan_mode_t mode;
		logic       dbl;
		logic [7:0] op_a;
		logic [7:0] op_b;
		logic [7:0] pass;
	} chan_req_t;

	function automatic chan_req_t pass_req(input logic [7:0] v);
		chan_req_t r;
		r.mode = MODE_PASS;
		r.dbl  = 1'b0;
		r.op_a = 8'd0;
		r.op_b = 8'd0;
		r.pass = v;
		return r;
	endfunction

	function automatic chan_req_t blend_req(input logic [3:0] cmd, input logic [7:0] a,
			input logic [7:0] b);
		chan_req_t r;
		r = pass_req(a);
		case (cmd)
			CMD_MULTIPLY: begin
				r.mode = MODE_DIV;
				r.op_a = a;
				r.op_b = b;
			end
			CMD_SUBTRACT: begin
				r.pass = (b > a) ? b - a : 8'd0;
			end
			CMD_SCREEN: begin
				r.mode = MODE_DIV_INV;
				r.op_a = CH_MAX - a;
				r.op_b = CH_MAX - b;
			end
			CMD_OVERLAY: begin
				r.dbl = 1'b1;
				if (b > OVERLAY_MID) begin
					r.mode = MODE_DIV_INV;
					r.op_a = CH_MAX - a;
					r.op_b = CH_MAX - b;
				end else begin
					r.mode = MODE_DIV;
					r.op_a = a;
					r.op_b = b;
				end
			end
			default: begin
				r.pass = a;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/rpb_channel.sv
module rpb_channel (
	input  logic              clk,
	input  rpb_pkg::chan_req_t req_s1,
	output logic [7:0]        result_s4
);
	import rpb_pkg::*;

	chan_mode_t  mode_s2, mode_s3;
	logic        dbl_s2;
	logic [15:0] prod_s2;
	logic [7:0]  pass_s2, pass_s3;
	logic [16:0] z_s3;
	logic [8:0]  q0_s3;

	logic [16:0] z_d;
	logic [24:0] scaled_d;
	logic [7:0]  sat_d;
	logic [17:0] rem_d;
	logic [8:0]  q_d;

	always_ff @(posedge clk) begin
		mode_s2 <= req_s1.mode;
		dbl_s2  <= req_s1.dbl;
		prod_s2 <= {8'd0, req_s1.op_a} * {8'd0, req_s1.op_b};
		pass_s2 <= req_s1.pass;
	end

	// Rounded x/255 is floor((x+127)/255); the quotient is estimated with 257/65536.
	always_comb begin
		z_d      = (dbl_s2 ? {prod_s2, 1'b0} : {1'b0, prod_s2}) + 17'd127;
		scaled_d = {z_d, 8'd0} + {8'd0, z_d};
		sat_d    = (prod_s2 > {8'd0, CH_MAX}) ? CH_MAX : prod_s2[7:0];
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		z_s3    <= z_d;
		q0_s3   <= scaled_d[24:16];
		pass_s3 <= (mode_s2 == MODE_SAT) ? sat_d : pass_s2;
	end

	always_comb begin
		rem_d = {1'b0, z_s3} + {9'd0, q0_s3} - {1'b0, q0_s3, 8'd0};
		q_d   = q0_s3 + {8'd0, (rem_d >= 18'd255)};
	end

	always_ff @(posedge clk) begin
		case (mode_s3)
			MODE_DIV:     result_s4 <= q_d[7:0];
			MODE_DIV_INV: result_s4 <= CH_MAX - q_d[7:0];
			default:      result_s4 <= pass_s3;
		endcase
	end

endmodule

FILE: rtl/rgb_pixel_blend_unit_top.sv
// Blends two 8-bit BGR pixels under a command, one request per clock. A request
// is taken whenever start is high, since busy never rises; its pixel passes
// through the four register stages of operand select, 8x8 multiply, quotient
// estimate and rounding correction, and appears on out_blue, out_green and
// out_red with done high for one cycle. The receiver cannot hold results
// off, so a result must be captured in the cycle that done is high.
module rgb_pixel_blend_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  command,
	input  logic [7:0]  first_blue,
	input  logic [7:0]  first_green,
	input  logic [7:0]  first_red,
	input  logic [7:0]  second_blue,
	input  logic [7:0]  second_green,
	input  logic [7:0]  second_red,
	output logic        done,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rpb_pkg::*;

	logic [7:0] green_offset_q, red_gain_q;
	logic       cfg_wr;
	logic       v_s1, v_s2, v_s3, v_s4;
	chan_req_t  req_b_d, req_g_d, req_r_d;
	chan_req_t  req_b_s1, req_g_s1, req_r_s1;
	logic [8:0] green_sum;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_offset_q <= GREEN_OFFSET_RESET;
			red_gain_q     <= RED_GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_GREEN_OFFSET: green_offset_q <= pwdata[7:0];
				REG_RED_GAIN:     red_gain_q     <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GREEN_OFFSET: prdata = {24'd0, green_offset_q};
			REG_RED_GAIN:     prdata = {24'd0, red_gain_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_comb begin
		green_sum = {1'b0, first_green} + {1'b0, green_offset_q};
		req_b_d   = blend_req(command, first_blue, second_blue);
		req_g_d   = blend_req(command, first_green, second_green);
		req_r_d   = blend_req(command, first_red, second_red);
		case (command)
			CMD_ADD_GREEN: begin
				req_b_d = pass_req(first_blue);
				req_g_d = pass_req(green_sum[8] ? CH_MAX : green_sum[7:0]);
				req_r_d = pass_req(first_red);
			end
			CMD_SCALE_RED: begin
				req_b_d      = pass_req(8'd0);
				req_g_d      = pass_req(first_green);
				req_r_d      = pass_req(8'd0);
				req_r_d.mode = MODE_SAT;
				req_r_d.op_a = first_red;
				req_r_d.op_b = red_gain_q;
			end
			CMD_REP_BLUE: begin
				req_b_d = pass_req(first_blue);
				req_g_d = pass_req(first_blue);
				req_r_d = pass_req(first_blue);
			end
			CMD_REP_GREEN: begin
				req_b_d = pass_req(first_green);
				req_g_d = pass_req(first_green);
				req_r_d = pass_req(first_green);
			end
			CMD_REP_RED: begin
				req_b_d = pass_req(first_red);
				req_g_d = pass_req(first_red);
				req_r_d = pass_req(first_red);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		req_b_s1 <= req_b_d;
		req_g_s1 <= req_g_d;
		req_r_s1 <= req_r_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign done = v_s4;

	rpb_channel u_blue (
		.clk       (clk),
		.req_s1    (req_b_s1),
		.result_s4 (out_blue)
	);

	rpb_channel u_green (
		.clk       (clk),
		.req_s1    (req_g_s1),
		.result_s4 (out_green)
	);

	rpb_channel u_red (
		.clk       (clk),
		.req_s1    (req_r_s1),
		.result_s4 (out_red)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("request did not complete after four cycles");

	a_scale_red_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 4) == CMD_SCALE_RED) |-> (out_blue == 8'd0))
		else $error("scale red did not clear blue");

	a_rep_green: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 4) == CMD_REP_GREEN) |->
		(out_blue == out_green && out_green == out_red))
		else $error("replicate green gave unequal channels");

	a_mult_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(command, 4) == CMD_MULTIPLY && $past(first_blue, 4) == 8'd0) |->
		(out_blue == 8'd0))
		else $error("multiply by zero gave a nonzero blue");

endmodule
